/* rtl/core/ichm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_pkg
// Shared types and constants of the iteration count hue colormap.
// ----------------------------------------------------------------------------
package ichm_pkg;

  // integer part of the hue, 0..250 fits in eight bits
  localparam int unsigned HUE_INT_BITS = 8;
  localparam int unsigned HUE_TOP_INT  = 250;

  // one color component
  localparam int unsigned COLOR_BITS = 8;
  typedef logic [COLOR_BITS-1:0] color_t;
  localparam color_t COLOR_MAX = 8'd250;

  // hue wheel: slope 250/60 = 25/6, segments 60 hue units wide
  localparam int unsigned SLOPE_NUM   = 25;
  localparam int unsigned SLOPE_BITS  = 5;
  localparam int unsigned SEG_SPAN    = 60;
  localparam int unsigned SEG_SPAN_X2 = 120;
  localparam int unsigned SEG_SPAN_X3 = 180;
  localparam int unsigned SEG_SPAN_X4 = 240;
  // 500 and 1000 color units, times the divisor 6
  localparam int unsigned WHEEL_MID   = 3000;
  localparam int unsigned WHEEL_END   = 6000;

  // integer part of 25*h, at most 6250
  localparam int unsigned VAL_BITS    = HUE_INT_BITS + SLOPE_BITS;

  // divide by 6 as multiply by ceil(2^16/6) and shift
  localparam int unsigned RECIP6       = 10923;
  localparam int unsigned RECIP_BITS   = 14;
  localparam int unsigned RECIP_SHIFT  = 16;

  // hue wheel segment, one-hot
  typedef enum logic [4:0] {
    SEG_RISE_G = 5'b00001,
    SEG_FALL_R = 5'b00010,
    SEG_RISE_B = 5'b00100,
    SEG_FALL_G = 5'b01000,
    SEG_RISE_R = 5'b10000
  } seg_t;

endpackage

/* rtl/core/ichm_hue_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_hue_div
// Hue scaling: count*250 over max_count as a pipelined restoring divider,
// one quotient bit per stage, saturating at 250.0.
// ----------------------------------------------------------------------------
module ichm_hue_div import ichm_pkg::*; #(
  parameter int unsigned COUNT_BITS        = 24,
  parameter int unsigned HUE_FRACTION_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic [COUNT_BITS-1:0]                     max_count,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [COUNT_BITS-1:0]                     in_count,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0] out_hue
);

  localparam int unsigned QB = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned PW = COUNT_BITS + HUE_INT_BITS;
  localparam logic [QB-1:0] HUE_TOP = QB'(HUE_TOP_INT) << HUE_FRACTION_BITS;

  logic [QB:0]           vld_r;
  logic [QB+1:0]         rdy;
  logic [QB:0]           sat_r;
  logic [COUNT_BITS-1:0] rem_r [QB+1];
  logic [QB-1:0]         nb_r  [QB+1];
  logic [QB-1:0]         q_r   [QB+1];

  logic [PW-1:0]         prod;
  logic                  sat_nxt;

  // back pressure: a stage takes a beat when empty or when it moves on
  assign rdy[QB+1] = out_ready;
  assign in_ready  = rdy[0];

  // front stage: count*250 and saturation check
  assign prod    = PW'(in_count) * PW'(HUE_TOP_INT);
  assign sat_nxt = (max_count == '0) || (in_count > max_count);
  assign rdy[0]  = ~vld_r[0] | rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
  end

  // top bits of the dividend start the remainder, the rest are shifted in
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem_r[0] <= prod[PW-1:HUE_INT_BITS];
      nb_r[0]  <= QB'(prod[HUE_INT_BITS-1:0]) << HUE_FRACTION_BITS;
      q_r[0]   <= '0;
      sat_r[0] <= sat_nxt;
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [COUNT_BITS:0]   sh;
    logic [COUNT_BITS:0]   df;
    logic                  ge;
    logic [COUNT_BITS-1:0] rem_nxt;

    assign sh      = {rem_r[k-1], nb_r[k-1][QB-1]};
    assign df      = sh - {1'b0, max_count};
    assign ge      = sh >= {1'b0, max_count};
    assign rem_nxt = ge ? df[COUNT_BITS-1:0] : sh[COUNT_BITS-1:0];
    assign rdy[k]  = ~vld_r[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld_r[k-1]) begin
        rem_r[k] <= rem_nxt;
        nb_r[k]  <= nb_r[k-1] << 1;
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        sat_r[k] <= sat_r[k-1];
      end
    end

    // partial remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (vld_r[k] && !sat_r[k]) |-> (rem_r[k] < max_count))
      else $error("divider remainder not below max_count");
  end

  // saturated counts map to the top of the hue range
  assign out_valid = vld_r[QB];
  assign out_hue   = sat_r[QB] ? HUE_TOP : q_r[QB];

  // quotient never passes the top of the hue range
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (q_r[QB] <= HUE_TOP || sat_r[QB]))
    else $error("hue quotient above 250");

endmodule

/* rtl/core/ichm_wheel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_wheel
// Piecewise-linear hue wheel: segment select, divide by 6, color assembly,
// three register stages.
// ----------------------------------------------------------------------------
module ichm_wheel import ichm_pkg::*; #(
  parameter int unsigned HUE_FRACTION_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0] in_hue,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output color_t                                    out_red,
  output color_t                                    out_green,
  output color_t                                    out_blue
);

  localparam int unsigned QB = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam int unsigned TW = QB + SLOPE_BITS;
  localparam int unsigned RW = VAL_BITS + RECIP_BITS;

  localparam logic [QB-1:0] H_SEG1 = QB'(SEG_SPAN)    << HUE_FRACTION_BITS;
  localparam logic [QB-1:0] H_SEG2 = QB'(SEG_SPAN_X2) << HUE_FRACTION_BITS;
  localparam logic [QB-1:0] H_SEG3 = QB'(SEG_SPAN_X3) << HUE_FRACTION_BITS;
  localparam logic [QB-1:0] H_SEG4 = QB'(SEG_SPAN_X4) << HUE_FRACTION_BITS;
  localparam logic [TW-1:0] T_MID  = TW'(WHEEL_MID)   << HUE_FRACTION_BITS;
  localparam logic [TW-1:0] T_END  = TW'(WHEEL_END)   << HUE_FRACTION_BITS;

  logic                s1_vld_r, s2_vld_r, s3_vld_r;
  logic                rdy1, rdy2, rdy3;
  seg_t                s1_seg_r, s2_seg_r;
  seg_t                seg_nxt;
  logic [VAL_BITS-1:0] s1_val_r;
  color_t              s2_q_r;
  logic [TW-1:0]       t;
  logic [TW-1:0]       x_nxt;
  logic [RW-1:0]       prod;
  color_t              red_nxt, green_nxt, blue_nxt;
  color_t              red_r, green_r, blue_r;

  // stage ready chain
  assign rdy3     = ~s3_vld_r | out_ready;
  assign rdy2     = ~s2_vld_r | rdy3;
  assign rdy1     = ~s1_vld_r | rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
    end
  end

  // stage 1: 25*h, pick the segment and the ramp offset within it
  assign t = TW'(in_hue) * TW'(SLOPE_NUM);

  always_comb begin
    priority if (in_hue < H_SEG1) begin
      seg_nxt = SEG_RISE_G;
      x_nxt   = t;
    end else if (in_hue < H_SEG2) begin
      seg_nxt = SEG_FALL_R;
      x_nxt   = T_MID - t;
    end else if (in_hue < H_SEG3) begin
      seg_nxt = SEG_RISE_B;
      x_nxt   = t - T_MID;
    end else if (in_hue < H_SEG4) begin
      seg_nxt = SEG_FALL_G;
      x_nxt   = T_END - t;
    end else begin
      seg_nxt = SEG_RISE_R;
      x_nxt   = t - T_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_seg_r <= seg_nxt;
      s1_val_r <= x_nxt[TW-1:HUE_FRACTION_BITS];
    end
  end

  // stage 2: divide by 6 through the reciprocal
  assign prod = RW'(s1_val_r) * RW'(RECIP6);

  always_ff @(posedge clk) begin
    if (rdy2 && s1_vld_r) begin
      s2_seg_r <= s1_seg_r;
      s2_q_r   <= prod[RECIP_SHIFT+COLOR_BITS-1:RECIP_SHIFT];
    end
  end

  // stage 3: place the ramp value and the constant components
  always_comb begin
    unique case (s2_seg_r)
      SEG_RISE_G: begin
        red_nxt = COLOR_MAX; green_nxt = s2_q_r;    blue_nxt = '0;
      end
      SEG_FALL_R: begin
        red_nxt = s2_q_r;    green_nxt = COLOR_MAX; blue_nxt = '0;
      end
      SEG_RISE_B: begin
        red_nxt = '0;        green_nxt = COLOR_MAX; blue_nxt = s2_q_r;
      end
      SEG_FALL_G: begin
        red_nxt = '0;        green_nxt = s2_q_r;    blue_nxt = COLOR_MAX;
      end
      SEG_RISE_R: begin
        red_nxt = s2_q_r;    green_nxt = '0;        blue_nxt = COLOR_MAX;
      end
      default: begin
        red_nxt = '0;        green_nxt = '0;        blue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = s3_vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ramp value out of the divide stays within the color range
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_q_r <= COLOR_MAX))
    else $error("ramp value above 250");

  // every wheel color has one component at full scale
  a_one_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == COLOR_MAX || out_green == COLOR_MAX ||
                   out_blue == COLOR_MAX))
    else $error("no component at full scale");

endmodule

/* rtl/core/iteration_count_hue_colormap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iteration_count_hue_colormap
// Maps a fractal iteration count to an RGB color on a hue wheel.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while the output is not stalled and returns
// one color beat per pixel, in order. The hue is count*250/max_count with
// HUE_FRACTION_BITS fraction bits, saturated at 250.0 for counts above
// max_count or a max_count of zero; the color follows a five-segment linear
// hue wheel, components 0..250. The pipeline has one front stage, one divider
// stage per hue bit of the restoring divider, and three hue wheel stages.
// Back pressure fills bubbles stage by stage. Write max_count only while no
// pixel is in flight.
module iteration_count_hue_colormap import ichm_pkg::*; #(
  parameter int unsigned COUNT_BITS        = 24,
  parameter int unsigned HUE_FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_iteration_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output color_t                out_red,
  output color_t                out_green,
  output color_t                out_blue
);

  localparam int unsigned QB = HUE_INT_BITS + HUE_FRACTION_BITS;

  logic [COUNT_BITS-1:0] max_count_r;
  logic                  hue_valid;
  logic                  hue_ready;
  logic [QB-1:0]         hue;

  // iteration limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= COUNT_BITS'(255);
    end else if (cfg_we) begin
      max_count_r <= cfg_wdata;
    end
  end

  // count to hue
  ichm_hue_div #(
    .COUNT_BITS        (COUNT_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_hue_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_count (max_count_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_count  (in_iteration_count),
    .out_valid (hue_valid),
    .out_ready (hue_ready),
    .out_hue   (hue)
  );

  // hue to color
  ichm_wheel #(
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
  ) u_wheel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hue_valid),
    .in_ready  (hue_ready),
    .in_hue    (hue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule
